// ===== src/bfdh_pkg.sv =====
package bfdh_pkg;

  // controller states, one-hot
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_SETUP = 7'b0001000,
    ST_ADV   = 7'b0010000,
    ST_PROBE = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 1'b1;

  // field widths and reset values
  localparam int CFG_DATA_W = 17;
  localparam int NH_W       = 4;
  localparam int KEY_W      = 64;
  localparam int LEN_W      = 4;
  localparam int HASH_W     = 32;
  localparam logic [CFG_DATA_W-1:0] BIT_COUNT_RST  = 17'h10000;
  localparam logic [NH_W-1:0]       NUM_HASHES_RST = 4'd7;

  // remainder unit: four dividend bits a cycle over a 32-bit word
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = HASH_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

endpackage

// ===== src/bfdh_ram.sv =====
module bfdh_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bloom_filter_double_hash_core.sv =====
// Flow: an accepted word passes the remainder unit, setup and the probes; only a query offers a result.
// A new word is accepted only once the last one has finished; the remainder unit reduces
//   the key halves, then one probe per cycle through the single-bit filter memory.
// Reset: synchronous, active low; afterwards a clearing pass writes every filter bit,
//   during which no word is accepted (configuration writes are taken).
module bloom_filter_double_hash_core #(
  parameter int MAX_BITS = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic [bfdh_pkg::KEY_W-1:0]           in_key,
  input  logic [bfdh_pkg::LEN_W-1:0]           in_key_length,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_present
);

  import bfdh_pkg::*;

  localparam int AW = $clog2(MAX_BITS);
  localparam int MW = $clog2(MAX_BITS + 1);

  // byte mask for a half of n bytes
  function automatic logic [HASH_W-1:0] byte_mask(input logic [2:0] n);
    logic [HASH_W-1:0] msk;
    case (n)
      3'd0:    msk = 32'h0000_0000;
      3'd1:    msk = 32'h0000_00FF;
      3'd2:    msk = 32'h0000_FFFF;
      3'd3:    msk = 32'h00FF_FFFF;
      default: msk = 32'hFFFF_FFFF;
    endcase
    return msk;
  endfunction

  // four restoring remainder steps
  function automatic logic [MW-1:0] mod_step(input logic [MW-1:0] rem,
                                             input logic [DIV_RADIX_BITS-1:0] bits,
                                             input logic [MW-1:0] m);
    logic [MW:0] x;
    x = {1'b0, rem};
    for (int j = DIV_RADIX_BITS - 1; j >= 0; j--) begin
      x = {x[MW-1:0], bits[j]};
      if (x >= {1'b0, m}) begin
        x = x - {1'b0, m};
      end
    end
    return x[MW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] bit_count_r, bit_count_nxt;
  logic [NH_W-1:0]       num_hashes_r, num_hashes_nxt;

  logic              op_r, op_nxt;
  logic [HASH_W-1:0] low_r, low_nxt;
  logic [HASH_W-1:0] high_r, high_nxt;
  logic [HASH_W-1:0] lsh_r, lsh_nxt;
  logic [HASH_W-1:0] hsh_r, hsh_nxt;
  logic [MW-1:0]     lrem_r, lrem_nxt;
  logic [MW-1:0]     hrem_r, hrem_nxt;
  logic [MW-1:0]     wrem_r, wrem_nxt;
  logic [MW-1:0]     wr_r, wr_nxt;
  logic [MW-1:0]     mwr_r, mwr_nxt;
  logic [HASH_W-1:0] h_r, h_nxt;
  logic [MW-1:0]     pos_r, pos_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [NH_W-1:0]   pcnt_r, pcnt_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              all_r, all_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_present_r, out_present_nxt;

  logic [HASH_W-1:0] mfull;
  logic [MW-1:0]     m;
  logic [LEN_W-1:0]  len_c;
  logic [2:0]        nlo, nhi;
  logic [KEY_W-1:0]  key_sh;
  logic [HASH_W:0]   hsum;
  logic [MW:0]       psum, pred;
  logic [MW-1:0]     padv;
  logic [MW-1:0]     w1p;
  logic              final_all;
  logic              can_finish;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  // effective modulus: zero acts as one, clamped to the store size
  always_comb begin
    if (bit_count_r == '0) begin
      mfull = 32'd1;
    end else if ({15'd0, bit_count_r} > 32'(MAX_BITS)) begin
      mfull = 32'(MAX_BITS);
    end else begin
      mfull = {15'd0, bit_count_r};
    end
    m = mfull[MW-1:0];
  end

  // key split into little-endian halves
  always_comb begin
    len_c = (in_key_length > 4'd8) ? 4'd8 : in_key_length;
    nlo   = len_c[3:1];
    nhi   = len_c[3:1] + {2'b00, len_c[0]};
    case (nlo)
      3'd0:    key_sh = in_key;
      3'd1:    key_sh = in_key >> 8;
      3'd2:    key_sh = in_key >> 16;
      3'd3:    key_sh = in_key >> 24;
      default: key_sh = in_key >> 32;
    endcase
  end

  // next salt: 32-bit wrap tracked in the remainder
  always_comb begin
    hsum = {1'b0, h_r} + {1'b0, high_r};
    psum = {1'b0, pos_r} + {1'b0, hrem_r};
    pred = (psum >= {1'b0, m}) ? psum - {1'b0, m} : psum;
    if (hsum[HASH_W]) begin
      if (pred[MW-1:0] >= wr_r) begin
        padv = pred[MW-1:0] - wr_r;
      end else begin
        padv = pred[MW-1:0] + mwr_r;
      end
    end else begin
      padv = pred[MW-1:0];
    end
  end

  assign w1p        = wrem_r + 1'b1;
  assign final_all  = all_r & (rd_pend_r ? ram_rdata : 1'b1);
  assign can_finish = (op_r == OP_INSERT) || !out_valid_r || !out_stall;

  // controller
  always_comb begin
    state_nxt       = state_r;
    bit_count_nxt   = bit_count_r;
    num_hashes_nxt  = num_hashes_r;
    op_nxt          = op_r;
    low_nxt         = low_r;
    high_nxt        = high_r;
    lsh_nxt         = lsh_r;
    hsh_nxt         = hsh_r;
    lrem_nxt        = lrem_r;
    hrem_nxt        = hrem_r;
    wrem_nxt        = wrem_r;
    wr_nxt          = wr_r;
    mwr_nxt         = mwr_r;
    h_nxt           = h_r;
    pos_nxt         = pos_r;
    dcnt_nxt        = dcnt_r;
    pcnt_nxt        = pcnt_r;
    clr_cnt_nxt     = clr_cnt_r;
    all_nxt         = rd_pend_r ? (all_r & ram_rdata) : all_r;
    rd_pend_nxt     = 1'b0;
    out_valid_nxt   = out_valid_r;
    out_present_nxt = out_present_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_r[AW-1:0];
    ram_wdata       = 1'b1;
    ram_raddr       = pos_r[AW-1:0];

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        REG_BIT_COUNT:  bit_count_nxt  = cfg_data;
        REG_NUM_HASHES: num_hashes_nxt = cfg_data[NH_W-1:0];
        default: ;
      endcase
    end

    // result register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = 1'b0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MAX_BITS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          low_nxt   = in_key[HASH_W-1:0] & byte_mask(nlo);
          high_nxt  = key_sh[HASH_W-1:0] & byte_mask(nhi);
          lsh_nxt   = in_key[HASH_W-1:0] & byte_mask(nlo);
          hsh_nxt   = key_sh[HASH_W-1:0] & byte_mask(nhi);
          lrem_nxt  = '0;
          hrem_nxt  = '0;
          wrem_nxt  = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        lrem_nxt = mod_step(lrem_r, lsh_r[HASH_W-1 -: DIV_RADIX_BITS], m);
        hrem_nxt = mod_step(hrem_r, hsh_r[HASH_W-1 -: DIV_RADIX_BITS], m);
        wrem_nxt = mod_step(wrem_r, {DIV_RADIX_BITS{1'b1}}, m);
        lsh_nxt  = lsh_r << DIV_RADIX_BITS;
        hsh_nxt  = hsh_r << DIV_RADIX_BITS;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        // 2^32 mod m from (2^32 - 1) mod m
        wr_nxt    = (w1p == m) ? '0 : w1p;
        mwr_nxt   = m - ((w1p == m) ? '0 : w1p);
        h_nxt     = low_r;
        pos_nxt   = lrem_r;
        pcnt_nxt  = 4'd1;
        all_nxt   = 1'b1;
        state_nxt = ST_ADV;
      end
      ST_ADV: begin
        h_nxt   = hsum[HASH_W-1:0];
        pos_nxt = padv;
        state_nxt = (num_hashes_r == '0) ? ST_FIN : ST_PROBE;
      end
      ST_PROBE: begin
        if (op_r == OP_INSERT) begin
          ram_we = 1'b1;
        end else begin
          rd_pend_nxt = 1'b1;
        end
        h_nxt    = hsum[HASH_W-1:0];
        pos_nxt  = padv;
        pcnt_nxt = pcnt_r + 1'b1;
        if (pcnt_r == num_hashes_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (can_finish) begin
          if (op_r == OP_QUERY) begin
            out_valid_nxt   = 1'b1;
            out_present_nxt = final_all;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      bit_count_r  <= BIT_COUNT_RST;
      num_hashes_r <= NUM_HASHES_RST;
      clr_cnt_r    <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bit_count_r  <= bit_count_nxt;
      num_hashes_r <= num_hashes_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    low_r         <= low_nxt;
    high_r        <= high_nxt;
    lsh_r         <= lsh_nxt;
    hsh_r         <= hsh_nxt;
    lrem_r        <= lrem_nxt;
    hrem_r        <= hrem_nxt;
    wrem_r        <= wrem_nxt;
    wr_r          <= wr_nxt;
    mwr_r         <= mwr_nxt;
    h_r           <= h_nxt;
    pos_r         <= pos_nxt;
    dcnt_r        <= dcnt_nxt;
    pcnt_r        <= pcnt_nxt;
    all_r         <= all_nxt;
    out_present_r <= out_present_nxt;
  end

  // filter bit store
  bfdh_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BITS)
  ) u_bits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_present = out_present_r;

endmodule
